### design/pcsh_pkg.sv
// Shared types, command codes and configuration constants for the pc sampling histogram.
package pcsh_pkg;

  // Default store size and bucket granularity.
  localparam int BUCKETS_DEF = 4096;
  localparam int SHIFT_DEF   = 3;

  // Field widths fixed by the item and result formats.
  localparam int PC_W    = 64;
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 32;
  localparam int INC_W   = 16;

  // Configuration port geometry: 64-bit registers at 8-byte spacing.
  localparam int APB_AW  = 6;
  localparam int APB_DW  = 64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STARTCLR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

  // Register indexes.
  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
  localparam logic [2:0] REG_CRIT_LOW   = 3'd2;
  localparam logic [2:0] REG_CRIT_HIGH  = 3'd3;
  localparam logic [2:0] REG_TICK_INC   = 3'd4;

  // Shared adder operations.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } pcsh_alu_op_t;

  // Input word.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PC_W-1:0]  sample_pc;
    logic [PC_W-1:0]  saved_pc;
    logic [IDX_W-1:0] read_index;
  } pcsh_item_t;

  // Result word.
  typedef struct packed {
    logic [CNT_W-1:0] read_data;
    logic             read_valid;
  } pcsh_result_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [PC_W-1:0]  range_low;
    logic [PC_W-1:0]  range_high;
    logic [PC_W-1:0]  crit_low;
    logic [PC_W-1:0]  crit_high;
    logic [INC_W-1:0] tick_increment;
  } pcsh_cfg_t;

endpackage

### design/pcsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pcsh_alu.sv
// Shared 64-bit adder/subtractor used for the tick compares and every counter update.
module pcsh_alu (
  input  pcsh_pkg::pcsh_alu_op_t       op,
  input  logic [pcsh_pkg::PC_W-1:0]    a,
  input  logic [pcsh_pkg::PC_W-1:0]    b,
  output logic [pcsh_pkg::PC_W-1:0]    res,
  output logic                         carry
);

  logic [pcsh_pkg::PC_W-1:0] b_eff;
  logic [pcsh_pkg::PC_W:0]   sum;

  // For a subtract the carry out is set when a >= b.
  always_comb begin
    b_eff = (op == pcsh_pkg::ALU_SUB) ? ~b : b;
    sum   = {1'b0, a} + {1'b0, b_eff} + (pcsh_pkg::PC_W + 1)'(op == pcsh_pkg::ALU_SUB);
    res   = sum[pcsh_pkg::PC_W-1:0];
    carry = sum[pcsh_pkg::PC_W];
  end

endmodule

### design/pcsh_cfg.sv
// Configuration register file behind the APB-style port.
module pcsh_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcsh_pkg::APB_AW-1:0]   paddr,
  input  logic [pcsh_pkg::APB_DW-1:0]   pwdata,
  output logic [pcsh_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output pcsh_pkg::pcsh_cfg_t           cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[pcsh_pkg::APB_AW-1:3];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_low      <= '0;
      cfg.range_high     <= '0;
      cfg.crit_low       <= '0;
      cfg.crit_high      <= '0;
      cfg.tick_increment <= pcsh_pkg::INC_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        pcsh_pkg::REG_RANGE_LOW:  cfg.range_low      <= pwdata;
        pcsh_pkg::REG_RANGE_HIGH: cfg.range_high     <= pwdata;
        pcsh_pkg::REG_CRIT_LOW:   cfg.crit_low       <= pwdata;
        pcsh_pkg::REG_CRIT_HIGH:  cfg.crit_high      <= pwdata;
        pcsh_pkg::REG_TICK_INC:   cfg.tick_increment <= pwdata[pcsh_pkg::INC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux; unused addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      pcsh_pkg::REG_RANGE_LOW:  prdata = cfg.range_low;
      pcsh_pkg::REG_RANGE_HIGH: prdata = cfg.range_high;
      pcsh_pkg::REG_CRIT_LOW:   prdata = cfg.crit_low;
      pcsh_pkg::REG_CRIT_HIGH:  prdata = cfg.crit_high;
      pcsh_pkg::REG_TICK_INC:   prdata = pcsh_pkg::APB_DW'(cfg.tick_increment);
      default:                  prdata = '0;
    endcase
  end

endmodule

### design/pc_sample_histogram.sv
// Top level: pc sampling histogram sequencer around one shared adder and one counter RAM.
// Stop, start, unknown commands and ticks while stopped strobe done in the cycle after accept.
// A read passes through S_RDMEM and S_RDOUT (registered RAM read); an enabled tick runs four
// compare steps and one slot check on the shared adder, then two serial read-modify-writes.
// Start with clear sweeps the RAM one word a cycle and strobes done when the sweep ends.
// Reset (synchronous) stops profiling and runs the same clearing sweep with busy high and no
// done strobe; done cannot be stalled by the receiver.
module pc_sample_histogram #(
  parameter int BUCKETS = pcsh_pkg::BUCKETS_DEF,
  parameter int SHIFT   = pcsh_pkg::SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pcsh_pkg::pcsh_item_t          item,
  output logic                          done,
  output pcsh_pkg::pcsh_result_t        result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcsh_pkg::APB_AW-1:0]   paddr,
  input  logic [pcsh_pkg::APB_DW-1:0]   pwdata,
  output logic [pcsh_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(BUCKETS);

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_CLEAR = 13'h0002,
    S_CRLO  = 13'h0004,
    S_CRHI  = 13'h0008,
    S_RGLO  = 13'h0010,
    S_RGHI  = 13'h0020,
    S_SLOT  = 13'h0040,
    S_RD0   = 13'h0080,
    S_WR0   = 13'h0100,
    S_RD1   = 13'h0200,
    S_WR1   = 13'h0400,
    S_RDMEM = 13'h0800,
    S_RDOUT = 13'h1000
  } state_t;

  state_t                       state;
  pcsh_pkg::pcsh_cfg_t          cfg;
  logic                         enabled;
  logic                         clr_reply;
  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                read_addr;
  logic [AW-1:0]                bucket;
  logic [pcsh_pkg::PC_W-1:0]    pc_work;
  logic [pcsh_pkg::PC_W-1:0]    pc_saved;
  logic [pcsh_pkg::PC_W-1:0]    diff;
  logic [pcsh_pkg::PC_W-1:0]    diff_sh;
  logic                         ge_flag;
  logic                         in_range;

  pcsh_pkg::pcsh_alu_op_t       alu_op;
  logic [pcsh_pkg::PC_W-1:0]    alu_a;
  logic [pcsh_pkg::PC_W-1:0]    alu_b;
  logic [pcsh_pkg::PC_W-1:0]    alu_res;
  logic                         alu_carry;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [pcsh_pkg::CNT_W-1:0]   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [pcsh_pkg::CNT_W-1:0]   ram_rdata;

  assign busy    = (state != S_IDLE);
  assign diff_sh = diff >> SHIFT;

  pcsh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcsh_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  pcsh_ram #(
    .WIDTH (pcsh_pkg::CNT_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand selection for the shared adder, one compare or update per state.
  always_comb begin
    alu_op = pcsh_pkg::ALU_SUB;
    alu_a  = pc_work;
    alu_b  = cfg.crit_low;
    unique case (state)
      S_CRHI: begin
        alu_a = cfg.crit_high;
        alu_b = pc_work;
      end
      S_RGLO: begin
        alu_b = cfg.range_low;
      end
      S_RGHI: begin
        alu_b = cfg.range_high;
      end
      S_SLOT: begin
        alu_a = diff_sh;
        alu_b = pcsh_pkg::PC_W'(BUCKETS);
      end
      S_WR0, S_WR1: begin
        alu_op = pcsh_pkg::ALU_ADD;
        alu_a  = pcsh_pkg::PC_W'(ram_rdata);
        alu_b  = pcsh_pkg::PC_W'(cfg.tick_increment);
      end
      default: ;
    endcase
  end

  // RAM port control: clearing sweep, counter write-back and read addressing.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = read_addr;
    unique case (state)
      S_CLEAR: ram_we = 1'b1;
      S_RD0:   ram_raddr = '0;
      S_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = alu_res[pcsh_pkg::CNT_W-1:0];
      end
      S_RD1:   ram_raddr = bucket;
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = bucket;
        ram_wdata = alu_res[pcsh_pkg::CNT_W-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      enabled   <= 1'b0;
      done      <= 1'b0;
      result    <= '0;
    end else begin
      done   <= 1'b0;
      result <= '0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (item.cmd)
              pcsh_pkg::CMD_TICK: begin
                if (enabled) begin
                  pc_work  <= item.sample_pc;
                  pc_saved <= item.saved_pc;
                  state    <= S_CRLO;
                end else begin
                  done <= 1'b1;
                end
              end
              pcsh_pkg::CMD_STARTCLR: begin
                enabled   <= 1'b1;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              pcsh_pkg::CMD_START: begin
                enabled <= 1'b1;
                done    <= 1'b1;
              end
              pcsh_pkg::CMD_STOP: begin
                enabled <= 1'b0;
                done    <= 1'b1;
              end
              pcsh_pkg::CMD_READ: begin
                if (32'(item.read_index) < 32'(BUCKETS)) begin
                  read_addr <= AW'(item.read_index);
                  state     <= S_RDMEM;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_addr == AW'(BUCKETS - 1)) begin
            state     <= S_IDLE;
            done      <= clr_reply;
            clr_reply <= 1'b0;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_CRLO: begin
          ge_flag <= alu_carry;
          state   <= S_CRHI;
        end
        S_CRHI: begin
          // Inside the critical window the saved pc stands in.
          if (ge_flag && alu_carry) begin
            pc_work <= pc_saved;
          end
          state <= S_RGLO;
        end
        S_RGLO: begin
          diff    <= alu_res;
          ge_flag <= alu_carry;
          state   <= S_RGHI;
        end
        S_RGHI: begin
          in_range <= ge_flag && !alu_carry;
          state    <= S_SLOT;
        end
        S_SLOT: begin
          // Out-of-range pcs and buckets past the store go to bucket 1.
          bucket <= (in_range && !alu_carry) ? diff_sh[AW-1:0] : AW'(1);
          state  <= S_RD0;
        end
        S_RD0:   state <= S_WR0;
        S_WR0:   state <= S_RD1;
        S_RD1:   state <= S_WR1;
        S_WR1: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_RDMEM: state <= S_RDOUT;
        S_RDOUT: begin
          result.read_data  <= ram_rdata;
          result.read_valid <= 1'b1;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/pcsh_checker.sv
// Port-level checks for the pc sampling histogram and their binding to the top level.
module pcsh_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input pcsh_pkg::pcsh_result_t result
);

  // A result word only appears once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobed while busy");

  // An accepted word either completes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither busy nor done");

  // A valid read is only flagged on a result strobe.
  a_valid_strobe: assert property (@(posedge clk) disable iff (rst)
    result.read_valid |-> done)
    else $error("read_valid without done");

  // Results that are not valid reads carry zero data.
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && !result.read_valid) |-> (result.read_data == '0))
    else $error("nonzero data on non-read result");

  // The clearing sweep holds the block busy right after reset.
  a_reset_sweep: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind pc_sample_histogram pcsh_checker u_pcsh_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pc sampling histogram: command words against a local profile.
module tb_top;

  localparam int BINS      = pcsh_pkg::BUCKETS_DEF;
  localparam int BIN_SHIFT = pcsh_pkg::SHIFT_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 210;

  // Command codes the block must ignore.
  localparam logic [pcsh_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [pcsh_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  // Directed profile window: 64 bytes (eight buckets) past the store end.
  localparam logic [pcsh_pkg::PC_W-1:0] DIR_BASE = 64'h1000;
  localparam logic [pcsh_pkg::PC_W-1:0] DIR_TOP  = DIR_BASE + 64'(8 * BINS + 64);

  typedef struct {
    bit                              is_cfg;
    logic [2:0]                      reg_idx;
    logic [pcsh_pkg::APB_DW-1:0]     value;
    pcsh_pkg::pcsh_item_t            word;
    bit                              typed;
    pcsh_pkg::pcsh_result_t          exp;
  } step_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  pcsh_pkg::pcsh_item_t          item;
  logic                          done;
  pcsh_pkg::pcsh_result_t        result;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pcsh_pkg::APB_AW-1:0]   paddr;
  logic [pcsh_pkg::APB_DW-1:0]   pwdata;
  logic [pcsh_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  // Expected counter reads, oldest first, and the directed expectation riding with a word.
  pcsh_pkg::pcsh_result_t        read_words_q[$];
  step_row_t                     plan_q[$];
  bit                            word_typed;
  pcsh_pkg::pcsh_result_t        word_exp;
  bit                            gaps_on;
  int                            mismatch_count;
  int                            idle_cycles;

  // Local copy of the profile state and its configuration.
  logic [pcsh_pkg::CNT_W-1:0]    model_counts [BINS];
  bit                            model_running;
  logic [pcsh_pkg::PC_W-1:0]     m_range_low;
  logic [pcsh_pkg::PC_W-1:0]     m_range_high;
  logic [pcsh_pkg::PC_W-1:0]     m_crit_low;
  logic [pcsh_pkg::PC_W-1:0]     m_crit_high;
  logic [pcsh_pkg::INC_W-1:0]    m_tick_inc;
  logic [pcsh_pkg::IDX_W-1:0]    last_bucket;

  pc_sample_histogram uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one command word to the local profile and return the word it reads back.
  function automatic pcsh_pkg::pcsh_result_t histogram_step(pcsh_pkg::pcsh_item_t w);
    logic [pcsh_pkg::PC_W-1:0] pc;
    logic [pcsh_pkg::PC_W-1:0] slot;
    pcsh_pkg::pcsh_result_t    r;
    r = '0;
    case (w.cmd)
      pcsh_pkg::CMD_TICK: begin
        if (model_running) begin
          pc = w.sample_pc;
          // Samples inside the critical window are charged to the saved pc.
          if (pc >= m_crit_low && pc <= m_crit_high) pc = w.saved_pc;
          model_counts[0] = model_counts[0] + pcsh_pkg::CNT_W'(m_tick_inc);
          slot = (pc - m_range_low) >> BIN_SHIFT;
          if (pc >= m_range_low && pc < m_range_high && slot < 64'(BINS)) begin
            model_counts[slot[pcsh_pkg::IDX_W-1:0]] =
              model_counts[slot[pcsh_pkg::IDX_W-1:0]] + pcsh_pkg::CNT_W'(m_tick_inc);
            last_bucket = slot[pcsh_pkg::IDX_W-1:0];
          end else begin
            model_counts[1] = model_counts[1] + pcsh_pkg::CNT_W'(m_tick_inc);
            last_bucket = pcsh_pkg::IDX_W'(1);
          end
        end
      end
      pcsh_pkg::CMD_STARTCLR: begin
        foreach (model_counts[i]) model_counts[i] = '0;
        model_running = 1'b1;
      end
      pcsh_pkg::CMD_START: model_running = 1'b1;
      pcsh_pkg::CMD_STOP:  model_running = 1'b0;
      pcsh_pkg::CMD_READ: begin
        if (w.read_index < BINS) begin
          r.read_data  = model_counts[w.read_index];
          r.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [pcsh_pkg::APB_DW-1:0] value);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.value   = value;
    plan_q.push_back(row);
  endfunction

  function automatic void add_cmd(logic [pcsh_pkg::CMD_W-1:0] cmd,
                                  logic [pcsh_pkg::PC_W-1:0] pc,
                                  logic [pcsh_pkg::PC_W-1:0] saved,
                                  logic [pcsh_pkg::IDX_W-1:0] idx,
                                  bit typed, logic [pcsh_pkg::CNT_W-1:0] data, logic valid);
    step_row_t row;
    row = '{default: '0};
    row.word.cmd        = cmd;
    row.word.sample_pc  = pc;
    row.word.saved_pc   = saved;
    row.word.read_index = idx;
    row.typed           = typed;
    row.exp.read_data   = data;
    row.exp.read_valid  = valid;
    plan_q.push_back(row);
  endfunction

  // Sample pcs mostly land in the profiled range or the critical window.
  function automatic logic [pcsh_pkg::PC_W-1:0] pick_pc();
    int                        roll;
    logic [pcsh_pkg::PC_W-1:0] pc;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      pc = m_range_low + 64'($urandom_range(0, 8 * BINS + 255));
    end else if (roll < 70) begin
      pc = m_crit_low + 64'($urandom_range(0, 16));
    end else if (roll < 82) begin
      case ($urandom_range(0, 5))
        0:       pc = m_range_low - 1;
        1:       pc = m_range_high;
        2:       pc = m_range_high - 1;
        3:       pc = m_crit_high;
        4:       pc = m_crit_high + 1;
        default: pc = m_crit_low - 1;
      endcase
    end else begin
      pc = {$urandom, $urandom};
    end
    return pc;
  endfunction

  // Register write over the configuration port; the local copy follows it.
  // The bus goes idle after each write so the next setup phase starts on a fresh edge.
  task automatic write_reg(logic [2:0] idx, logic [pcsh_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pcsh_pkg::REG_RANGE_LOW:  m_range_low  = value;
      pcsh_pkg::REG_RANGE_HIGH: m_range_high = value;
      pcsh_pkg::REG_CRIT_LOW:   m_crit_low   = value;
      pcsh_pkg::REG_CRIT_HIGH:  m_crit_high  = value;
      pcsh_pkg::REG_TICK_INC:   m_tick_inc   = value[pcsh_pkg::INC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one command word, with an occasional idle gap before it.
  task automatic issue_word(pcsh_pkg::pcsh_item_t w, bit typed, pcsh_pkg::pcsh_result_t exp);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    word_typed <= typed;
    word_exp   <= exp;
    start      <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Stop offering words and wait until every expected word has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (read_words_q.size() != 0 || busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic apply_setting(int ph);
    logic [pcsh_pkg::PC_W-1:0]  lo;
    logic [pcsh_pkg::PC_W-1:0]  hi;
    logic [pcsh_pkg::PC_W-1:0]  clo;
    logic [pcsh_pkg::PC_W-1:0]  chi;
    logic [pcsh_pkg::INC_W-1:0] inc;
    case (ph)
      0: begin
        // Whole address space profiled, critical window at the very top.
        lo  = '0;
        hi  = '1;
        clo = '1;
        chi = '1;
        inc = 16'd1;
      end
      1: begin
        // Range pinned to the top of memory; every sample is redirected.
        lo  = 64'hFFFF_FFFF_FFFF_FFFF - 64'(8 * BINS + 4000);
        hi  = '1;
        clo = '0;
        chi = '1;
        inc = 16'hFFFF;
      end
      2: begin
        // Inverted range: everything falls into the outside bucket.
        lo  = '1;
        hi  = '0;
        clo = {$urandom, $urandom};
        chi = clo + 64'($urandom_range(0, 64));
        inc = 16'h8001;
      end
      default: begin
        lo  = {$urandom, $urandom} >> 1;
        hi  = lo + 64'($urandom_range(16, 8 * BINS + 512));
        clo = lo + 64'($urandom_range(0, 8 * BINS));
        chi = clo + 64'($urandom_range(0, 64));
        inc = (ph == PHASES - 1) ? 16'd0 : 16'($urandom_range(0, 65535));
      end
    endcase
    write_reg(pcsh_pkg::REG_RANGE_LOW, lo);
    write_reg(pcsh_pkg::REG_RANGE_HIGH, hi);
    write_reg(pcsh_pkg::REG_CRIT_LOW, clo);
    write_reg(pcsh_pkg::REG_CRIT_HIGH, chi);
    write_reg(pcsh_pkg::REG_TICK_INC, 64'(inc));
  endtask

  // Check returned words in order and track what was accepted.
  always @(posedge clk) begin : monitor
    pcsh_pkg::pcsh_result_t want;
    pcsh_pkg::pcsh_result_t calc;
    if (!rst) begin
      if (done) begin
        if (read_words_q.size() == 0) begin
          $display("%0t: unexpected word data=%h valid=%b", $time,
                   result.read_data, result.read_valid);
          mismatch_count++;
        end else begin
          want = read_words_q.pop_front();
          if (result.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h got %h", $time,
                     want.read_data, result.read_data);
            mismatch_count++;
          end
          if (result.read_valid !== want.read_valid) begin
            $display("%0t: read_valid expected %b got %b", $time,
                     want.read_valid, result.read_valid);
            mismatch_count++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        calc = histogram_step(item);
        read_words_q.push_back(word_typed ? word_exp : calc);
      end
      // Watchdog on cycles with no traffic at all.
      if ((start && busy === 1'b0) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("pc_sample_histogram: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    pcsh_pkg::pcsh_item_t w;
    int                   roll;
    rst            <= 1'b1;
    start          <= 1'b0;
    item           <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    word_typed     <= 1'b0;
    word_exp       <= '0;
    gaps_on        = 1'b1;
    mismatch_count = 0;
    idle_cycles    = 0;
    foreach (model_counts[i]) model_counts[i] = '0;
    model_running = 1'b0;
    m_range_low   = '0;
    m_range_high  = '0;
    m_crit_low    = '0;
    m_crit_high   = '0;
    m_tick_inc    = 16'd1;
    last_bucket   = '0;

    // Directed plan: reset state, stopped ticks, ignored commands, bucket edges.
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd0, 1, 32'd0, 1'b1);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'hFFF, 1, 32'd0, 1'b1);
    add_cmd(pcsh_pkg::CMD_TICK, '0, '1, 12'd0, 1, 32'd0, 1'b0);
    add_cmd(CMD_UNUSED_LO, '1, '1, 12'hFFF, 1, 32'd0, 1'b0);
    add_cmd(CMD_UNUSED_HI, '0, '0, 12'd0, 1, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_START, '0, '0, 12'd0, 1, 32'd0, 1'b0);
    // Pc zero sits in the reset critical window; empty range sends it to bucket 1.
    add_cmd(pcsh_pkg::CMD_TICK, '0, '1, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd1, 1, 32'd1, 1'b1);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd0, 1, 32'd1, 1'b1);
    add_cfg(pcsh_pkg::REG_RANGE_LOW, DIR_BASE);
    add_cfg(pcsh_pkg::REG_RANGE_HIGH, DIR_TOP);
    add_cfg(pcsh_pkg::REG_CRIT_LOW, 64'hFFFF_FFFF_FFFF_FF00);
    add_cfg(pcsh_pkg::REG_CRIT_HIGH, '1);
    add_cfg(pcsh_pkg::REG_TICK_INC, 64'hFFFF);
    // Low buckets overlap the total and outside buckets.
    add_cmd(pcsh_pkg::CMD_TICK, DIR_BASE, '0, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_TICK, DIR_BASE + 8, '0, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_TICK, DIR_BASE + 64'(8 * BINS - 1), '0, 12'd0, 0, 32'd0, 1'b0);
    // Inside the range but past the last bucket.
    add_cmd(pcsh_pkg::CMD_TICK, DIR_BASE + 64'(8 * BINS), '0, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_TICK, '1, DIR_BASE + 16, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_TICK, DIR_BASE - 1, '0, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd1, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd2, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'hFFF, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_STOP, '0, '0, 12'd0, 1, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_TICK, DIR_BASE, '0, 12'd0, 1, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd0, 0, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_STARTCLR, '0, '0, 12'd0, 1, 32'd0, 1'b0);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'd0, 1, 32'd0, 1'b1);
    add_cmd(pcsh_pkg::CMD_READ, '0, '0, 12'hFFF, 1, 32'd0, 1'b1);

    // Reset, then let the clearing sweep finish.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        wait_drained();
        write_reg(plan_q[i].reg_idx, plan_q[i].value);
      end else begin
        issue_word(plan_q[i].word, plan_q[i].typed, plan_q[i].exp);
      end
    end

    // Random phases, one configuration each; one phase runs without gaps.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      apply_setting(ph);
      gaps_on = (ph != 3);
      repeat (PHASE_WORDS) begin
        w.sample_pc = pick_pc();
        w.saved_pc  = pick_pc();
        roll = $urandom_range(0, 99);
        if (roll < 40) w.read_index = pcsh_pkg::IDX_W'($urandom_range(0, BINS - 1));
        else if (roll < 60) w.read_index = pcsh_pkg::IDX_W'($urandom_range(0, 3));
        else w.read_index = last_bucket;
        roll = $urandom_range(0, 99);
        if (roll < 58) w.cmd = pcsh_pkg::CMD_TICK;
        else if (roll < 83) w.cmd = pcsh_pkg::CMD_READ;
        else if (roll < 89) w.cmd = pcsh_pkg::CMD_START;
        else if (roll < 92) w.cmd = pcsh_pkg::CMD_STOP;
        else if (roll < 99) w.cmd = CMD_UNUSED_LO + pcsh_pkg::CMD_W'($urandom_range(0, 2));
        else w.cmd = pcsh_pkg::CMD_STARTCLR;
        issue_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pc_sample_histogram: match");
    end else begin
      $display("pc_sample_histogram: mismatch");
    end
    $finish;
  end

endmodule
